// ===== rtl/hps_pkg.sv =====
// Package: shared constants and the byte-wide CRC-32 step for the peer selector.
package hps_pkg;

    localparam int unsigned HashW     = 64;
    localparam int unsigned CrcW      = 32;
    localparam int unsigned HealthW   = 17;
    localparam int unsigned TimesW    = 64;
    localparam int unsigned CountW    = 5;
    localparam int unsigned CfgW      = 6;
    localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;
    localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;

    localparam logic [1:0] ModeWrite  = 2'd0;
    localparam logic [1:0] ModeBegin  = 2'd1;
    localparam logic [1:0] ModeSelect = 2'd2;

    // Fold one byte into a reflected CRC-32, LSB first.
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [7:0] data);
        logic [CrcW-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/hps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/hash_peer_selector_with_rehash.sv =====
// Top level: hash-based peer selector with CRC-32 rehash and peer health table.
//
// A word with mode 0 writes one peer entry, mode 1 starts a request from the
// cookie digest plus the client address, and mode 2 selects a peer. Each word
// gives exactly one result word. Modes 0, 1, 3 and an immediate round robin
// fallback go from acceptance through the done state into the output register.
// A selection probe runs the byte-serial unit that forms the hash remainder by
// the peer count together with the CRC-32 of the hash, then reads the peer
// table and then evaluates. With up to twenty probes per selection, the result
// moves from the done state into the output register before the next word is
// taken. A result that waits for the output side stalls the input only while
// it cannot move into the output register. The peer tables sit in two
// synchronous RAMs; per-entry valid bits make unwritten entries read as zero,
// so no clearing pass is run. A new word is accepted while the previous result
// still waits in the output register.
module hash_peer_selector_with_rehash #(
    parameter int unsigned MAX_PEERS   = 32,
    parameter int unsigned PROBE_LIMIT = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [hps_pkg::CfgW-1:0]      cfg_wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [4:0]                    peer_addr,
    input  logic                          peer_down,
    input  logic [7:0]                    peer_fails,
    input  logic [7:0]                    peer_max_fails,
    input  logic [31:0]                   peer_fail_timeout,
    input  logic [31:0]                   peer_accessed,
    input  logic [63:0]                   cookie_digest,
    input  logic                          cookie_present,
    input  logic [31:0]                   client_ipv4,
    input  logic [31:0]                   now_seconds,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4:0]                    chosen_peer,
    output logic                          use_round_robin,
    output logic [4:0]                    peers_skipped
);

    import hps_pkg::*;

    localparam int unsigned AW = $clog2(MAX_PEERS);
    localparam int unsigned TW = AW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_EVAL,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CfgW-1:0]        peer_count_reg;
    logic [MAX_PEERS-1:0]   tried_reg;
    logic [MAX_PEERS-1:0]   hvalid_reg;
    logic [MAX_PEERS-1:0]   tvalid_reg;
    logic [HashW-1:0]       running_hash_reg;
    logic [CountW-1:0]      probe_count_reg;
    logic                   armed_reg;
    logic [HashW-1:0]       h_reg;
    logic [HashW-1:0]       hs_reg;
    logic [TW-1:0]          rem_reg;
    logic [CrcW-1:0]        crc_reg;
    logic [2:0]             step_reg;
    logic [31:0]            now_reg;
    logic [CountW-1:0]      skip_reg;
    logic [AW-1:0]          res_peer_reg;
    logic                   res_rr_reg;
    logic                   out_valid_reg;
    logic [4:0]             out_peer_reg;
    logic                   out_rr_reg;
    logic [CountW-1:0]      out_skip_reg;

    logic                   accept;
    logic [TW-1:0]          n_eff;
    logic [TW-1:0]          rem_next;
    logic [CrcW-1:0]        crc_next;
    logic [AW-1:0]          probe_p;
    logic [AW-1:0]          wr_addr;
    logic                   wr_addr_ok;
    logic                   h_we;
    logic [AW-1:0]          h_waddr;
    logic [HealthW-1:0]     h_wdata;
    logic                   t_we;
    logic [HealthW-1:0]     h_rdata;
    logic [TimesW-1:0]      t_rdata;
    logic [HealthW-1:0]     hv;
    logic [TimesW-1:0]      tv;
    logic                   untried;
    logic                   healthy;
    logic                   expired;
    logic                   take;
    logic [33:0]            age;
    logic [CountW-1:0]      probe_inc;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign probe_p    = rem_reg[AW-1:0];
    assign wr_addr    = AW'(peer_addr);
    assign wr_addr_ok = (32'(peer_addr) < MAX_PEERS);

    // Clamp the configured peer count to the table size
    assign n_eff = (32'(peer_count_reg) > MAX_PEERS) ? TW'(MAX_PEERS) : TW'(peer_count_reg);

    // Eight remainder bits and one CRC byte per cycle
    always_comb
    begin
        logic [TW-1:0] r;
        logic [TW:0]   t;
        r = rem_reg;
        for (int i = 0; i < 8; i++) begin
            t = {r, hs_reg[HashW-1-i]};
            if (t >= {1'b0, n_eff})
            begin
                t = t - {1'b0, n_eff};
            end
            r = t[TW-1:0];
        end
        rem_next = r;
        crc_next = crc_byte(crc_reg, h_reg[8*step_reg +: 8]);
    end

    // Peer health evaluation on the table read data
    assign hv      = hvalid_reg[probe_p] ? h_rdata : '0;
    assign tv      = tvalid_reg[probe_p] ? t_rdata : '0;
    assign untried = !tried_reg[probe_p];
    assign healthy = (hv[7:0] == 8'd0) || (hv[15:8] < hv[7:0]);
    assign age     = {2'b00, now_reg} - {2'b00, tv[31:0]};
    assign expired = $signed(age) > $signed({2'b00, tv[63:32]});
    assign take    = untried && !hv[16] && (healthy || expired);
    assign probe_inc = (probe_count_reg < CountW'(31)) ? probe_count_reg + 1'b1
                                                        : probe_count_reg;

    // Table write port: mode 0 writes, a timed-out peer gets its fails cleared
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = wr_addr;
        h_wdata = {peer_down, peer_fails, peer_max_fails};
        t_we    = accept && (mode == ModeWrite) && wr_addr_ok;
        if (t_we)
        begin
            h_we = 1'b1;
        end
        else if (state_reg == S_EVAL && take && !healthy)
        begin
            h_we    = 1'b1;
            h_waddr = probe_p;
            h_wdata = {hv[16], 8'd0, hv[7:0]};
        end
    end

    hps_ram #(.WIDTH(HealthW), .DEPTH(MAX_PEERS)) u_health (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (state_reg == S_RD),
        .raddr (probe_p),
        .rdata (h_rdata)
    );

    hps_ram #(.WIDTH(TimesW), .DEPTH(MAX_PEERS)) u_times (
        .clk   (clk),
        .we    (t_we),
        .waddr (wr_addr),
        .wdata ({peer_fail_timeout, peer_accessed}),
        .re    (state_reg == S_RD),
        .raddr (probe_p),
        .rdata (t_rdata)
    );

    // Sequencer, request state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            peer_count_reg   <= CfgW'(1);
            tried_reg        <= '0;
            hvalid_reg       <= '0;
            tvalid_reg       <= '0;
            running_hash_reg <= '0;
            probe_count_reg  <= '0;
            armed_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                peer_count_reg <= cfg_wr_data;
            end
            if (h_we)
            begin
                hvalid_reg[h_waddr] <= 1'b1;
            end
            if (t_we)
            begin
                tvalid_reg[wr_addr] <= 1'b1;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_peer_reg <= '0;
                        res_rr_reg   <= 1'b0;
                        skip_reg     <= '0;
                        now_reg      <= now_seconds;
                        h_reg        <= running_hash_reg;
                        hs_reg       <= running_hash_reg;
                        rem_reg      <= '0;
                        crc_reg      <= CrcInit;
                        step_reg     <= '0;
                        state_reg    <= S_DONE;
                        if (mode == ModeBegin)
                        begin
                            running_hash_reg <= cookie_digest + {32'd0, client_ipv4};
                            tried_reg        <= '0;
                            probe_count_reg  <= '0;
                            armed_reg        <= cookie_present;
                        end
                        else if (mode == ModeSelect)
                        begin
                            if (32'(probe_count_reg) > PROBE_LIMIT || n_eff <= TW'(1)
                                || !armed_reg)
                            begin
                                res_rr_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_MOD;
                            end
                        end
                    end
                end
                S_MOD:
                begin
                    rem_reg  <= rem_next;
                    crc_reg  <= crc_next;
                    hs_reg   <= hs_reg << 8;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd7)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    crc_reg   <= crc_reg ^ CrcInit;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (untried)
                    begin
                        tried_reg[probe_p] <= 1'b1;
                    end
                    if (take)
                    begin
                        running_hash_reg <= h_reg;
                        res_peer_reg     <= probe_p;
                        state_reg        <= S_DONE;
                    end
                    else
                    begin
                        if (untried)
                        begin
                            skip_reg <= skip_reg + 1'b1;
                        end
                        probe_count_reg <= probe_inc;
                        if (32'(probe_inc) >= PROBE_LIMIT)
                        begin
                            res_rr_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            h_reg     <= h_reg + {32'd0, crc_reg};
                            hs_reg    <= h_reg + {32'd0, crc_reg};
                            rem_reg   <= '0;
                            crc_reg   <= CrcInit;
                            step_reg  <= '0;
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_peer_reg  <= res_rr_reg ? 5'd0 : 5'(res_peer_reg);
                        out_rr_reg    <= res_rr_reg;
                        out_skip_reg  <= skip_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign chosen_peer     = out_peer_reg;
    assign use_round_robin = out_rr_reg;
    assign peers_skipped   = out_skip_reg;

endmodule

// ===== rtl/hps_checker.sv =====
// Checker: port-level properties of the peer selector, bound to the top level.
module hps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] chosen_peer,
    input logic       use_round_robin,
    input logic [4:0] peers_skipped
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_peer)
            && $stable(use_round_robin) && $stable(peers_skipped))
        else $error("result word changed while stalled");

    // A fallback never names a peer
    a_rr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && use_round_robin |-> chosen_peer == 5'd0)
        else $error("round robin fallback with nonzero peer");

    // Skips are bounded by the probe limit
    a_skip_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peers_skipped <= 5'd20)
        else $error("too many peers skipped");

endmodule

bind hash_peer_selector_with_rehash hps_checker u_hps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .chosen_peer     (chosen_peer),
    .use_round_robin (use_round_robin),
    .peers_skipped   (peers_skipped)
);
